[rtl/core/rip_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rip_pkg
// Shared widths, command codes and the control/status bundles of the
// random index picker.
// ----------------------------------------------------------------------------
package rip_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned RV_W     = 32;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned STEP_W   = $clog2(RV_W);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  localparam logic [CMD_W-1:0] CMD_PICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLAIM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic load_in;
    logic div_init;
    logic div_step;
    logic set_addr_claim;
    logic rd_addr_a;
    logic rd_count;
    logic wr_count;
    logic wr_addr_a;
    logic sweep;
    logic load_res;
    logic res_ok;
    logic res_pick;
  } rip_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             can_pick;
    logic             claim_in_range;
    logic             claim_match;
    logic             div_last;
    logic             sweep_last;
  } rip_sts_t;

endpackage
`default_nettype wire

[rtl/core/rip_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rip_in_if
// Command channel: valid/ready with command, random word and index.
// ----------------------------------------------------------------------------
interface rip_in_if;
  import rip_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [RV_W-1:0]   random_value;
  logic [IDX_W-1:0]  index;

  modport source (output valid, output cmd, output random_value, output index, input ready);
  modport sink   (input valid, input cmd, input random_value, input index, output ready);
endinterface
`default_nettype wire

[rtl/core/rip_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rip_out_if
// Result channel: valid/ready with status, picked index and drawn count.
// ----------------------------------------------------------------------------
interface rip_out_if;
  import rip_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [IDX_W-1:0]  picked_index;
  logic [CNT_W-1:0]  count_after;

  modport source (output valid, output status, output picked_index, output count_after,
                  input ready);
  modport sink   (input valid, input status, input picked_index, input count_after,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/rip_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rip_cfg_if
// Configuration write channel for the size_in_use register.
// ----------------------------------------------------------------------------
interface rip_cfg_if;
  import rip_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_in_use;

  modport source (output valid, output size_in_use, input ready);
  modport sink   (input valid, input size_in_use, output ready);
endinterface
`default_nettype wire

[rtl/core/rip_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rip_datapath
// Permutation table memory, drawn count, bit-serial modulo unit and the
// result register.
// ----------------------------------------------------------------------------
module rip_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rip_pkg::SIZE_W-1:0]  cfg_size_i,
  input  logic [rip_pkg::CMD_W-1:0]   cmd_i,
  input  logic [rip_pkg::RV_W-1:0]    random_value_i,
  input  logic [rip_pkg::IDX_W-1:0]   index_i,
  input  rip_pkg::rip_ctl_t           ctl_i,
  output rip_pkg::rip_sts_t           sts_o,
  output logic                        status_o,
  output logic [rip_pkg::IDX_W-1:0]   picked_index_o,
  output logic [rip_pkg::CNT_W-1:0]   count_after_o
);
  import rip_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CLOG = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW   = (CLOG < SIZE_W) ? CLOG : SIZE_W;

  logic [SIZE_W-1:0] size_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [RV_W-1:0]   rv_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     rem_q;
  logic [CW-1:0]     d_q;
  logic [STEP_W-1:0] step_q;
  logic [AW-1:0]     addr_a_q;
  logic [AW-1:0]     a_q;
  logic [AW-1:0]     b_q;
  logic [AW-1:0]     sweep_q;
  logic [AW-1:0]     rdata_q;
  logic              status_q;
  logic [IDX_W-1:0]  picked_q;
  logic [CNT_W-1:0]  cnt_out_q;
  logic [AW-1:0]     mem_q [TABLE_DEPTH];

  logic [CW-1:0]     eff;
  logic [CW:0]       trial;
  logic              trial_ge;
  logic [CW-1:0]     rem_next;
  logic              div_last;
  logic              sweep_last;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  assign eff = (32'(size_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(size_q);

  // restoring division, one quotient bit per step
  assign trial    = {rem_q, rv_q[RV_W-1]};
  assign trial_ge = trial >= {1'b0, d_q};
  assign rem_next = trial_ge ? CW'(trial - {1'b0, d_q}) : CW'(trial);
  assign div_last = step_q == STEP_W'(RV_W - 1);

  assign sweep_last = sweep_q == AW'(TABLE_DEPTH - 1);

  assign mem_we    = ctl_i.sweep | ctl_i.wr_count | ctl_i.wr_addr_a;
  assign mem_waddr = ctl_i.sweep ? sweep_q : (ctl_i.wr_count ? AW'(count_q) : addr_a_q);
  assign mem_wdata = ctl_i.sweep ? sweep_q : (ctl_i.wr_count ? a_q : b_q);
  assign mem_re    = ctl_i.rd_addr_a | ctl_i.rd_count;
  assign mem_raddr = ctl_i.rd_addr_a ? addr_a_q : AW'(count_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RESET;
      count_q <= '0;
      sweep_q <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_size_i;
      end
      if (ctl_i.sweep) begin
        count_q <= '0;
        sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
      end else if (ctl_i.wr_addr_a) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q <= cmd_i;
      rv_q  <= random_value_i;
      idx_q <= index_i;
    end
    if (ctl_i.div_init) begin
      rem_q  <= '0;
      d_q    <= eff - count_q;
      step_q <= '0;
    end else if (ctl_i.div_step) begin
      rem_q  <= rem_next;
      rv_q   <= rv_q << 1;
      step_q <= step_q + STEP_W'(1);
    end
    if (ctl_i.div_step && div_last) begin
      addr_a_q <= AW'(count_q) + AW'(rem_next);
    end else if (ctl_i.set_addr_claim) begin
      addr_a_q <= AW'(idx_q);
    end
    if (ctl_i.rd_count) begin
      a_q <= rdata_q;
    end
    if (ctl_i.wr_count) begin
      b_q <= rdata_q;
    end
    if (ctl_i.load_res) begin
      status_q  <= ~ctl_i.res_ok;
      picked_q  <= ctl_i.res_pick ? IDX_W'(a_q) : '0;
      cnt_out_q <= CNT_W'(count_q);
    end
  end

  always_comb begin
    sts_o.cmd            = cmd_q;
    sts_o.can_pick       = count_q < eff;
    sts_o.claim_in_range = (32'(idx_q) < 32'(eff)) && (32'(idx_q) >= 32'(count_q));
    sts_o.claim_match    = 32'(a_q) == 32'(idx_q);
    sts_o.div_last       = div_last;
    sts_o.sweep_last     = sweep_last;
  end

  assign status_o       = status_q;
  assign picked_index_o = picked_q;
  assign count_after_o  = cnt_out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("drawn count beyond table depth");
  a_rem_lt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div_step |-> rem_q < d_q)
    else $error("modulo remainder not below divisor");
  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rd_addr_a |-> (32'(addr_a_q) < 32'(eff)) && (32'(addr_a_q) >= 32'(count_q)))
    else $error("swap address outside undrawn range");
`endif
endmodule
`default_nettype wire

[rtl/core/rip_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rip_ctrl
// Controller: sequences table sweep, modulo, swap and result handoff.
// ----------------------------------------------------------------------------
module rip_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rip_pkg::rip_sts_t  sts_i,
  output rip_pkg::rip_ctl_t  ctl_o
);
  import rip_pkg::*;

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DEC  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_RDA  = 4'd4;
  localparam logic [3:0] ST_RDB  = 4'd5;
  localparam logic [3:0] ST_SW1  = 4'd6;
  localparam logic [3:0] ST_SW2  = 4'd7;
  localparam logic [3:0] ST_CLR  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ok_q, ok_d;
  logic       pick_q, pick_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    ok_d    = ok_q;
    pick_d  = pick_q;
    unique case (state_q)
      ST_INIT: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_DEC;
        end
      end
      ST_DEC: begin
        ok_d    = 1'b0;
        pick_d  = 1'b0;
        state_d = ST_FIN;
        unique case (sts_i.cmd)
          CMD_PICK: begin
            if (sts_i.can_pick) begin
              ctl_o.div_init = 1'b1;
              state_d        = ST_DIV;
            end
          end
          CMD_CLAIM: begin
            if (sts_i.claim_in_range) begin
              ctl_o.set_addr_claim = 1'b1;
              state_d              = ST_RDA;
            end
          end
          CMD_CLEAR: begin
            state_d = ST_CLR;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_RDA;
        end
      end
      ST_RDA: begin
        ctl_o.rd_addr_a = 1'b1;
        state_d         = ST_RDB;
      end
      ST_RDB: begin
        ctl_o.rd_count = 1'b1;
        state_d        = ST_SW1;
      end
      ST_SW1: begin
        if (sts_i.cmd == CMD_CLAIM && !sts_i.claim_match) begin
          ok_d    = 1'b0;
          pick_d  = 1'b0;
          state_d = ST_FIN;
        end else begin
          ctl_o.wr_count = 1'b1;
          state_d        = ST_SW2;
        end
      end
      ST_SW2: begin
        ctl_o.wr_addr_a = 1'b1;
        ok_d            = 1'b1;
        pick_d          = 1'b1;
        state_d         = ST_FIN;
      end
      ST_CLR: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          ok_d    = 1'b1;
          pick_d  = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_res = 1'b1;
          ctl_o.res_ok   = ok_q;
          ctl_o.res_pick = pick_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.load_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ok_q        <= 1'b0;
      pick_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      pick_q      <= pick_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_DEC)
    else $error("accepted transaction not decoded");
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_res |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.wr_addr_a |-> $past(ctl_o.wr_count))
    else $error("second swap write without first");
`endif
endmodule
`default_nettype wire

[rtl/core/random_index_picker_no_repeat.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// random_index_picker_no_repeat
// Draws indices without repetition from a permutation table (partial shuffle).
//
// Channels: in_i carries cmd (pick, claim, clear), random_value and index;
// out_o returns status, picked_index and count_after, one transaction per
// command. cfg_i writes size_in_use and is always ready; write it only idle.
// Pick runs the bit-serial modulo unit, one remainder bit per cycle, then a
// two-entry swap through the single-port table memory. Claim reads both
// entries and swaps them only when the claimed entry is in its home position;
// a refused command goes straight to the result. Clear rewrites every entry.
// One command is processed at a time; in_i.ready rises again as the result
// enters the output register.
// Reset: the table is swept to identity, entry by entry, while in_i.ready
// stays low; size_in_use returns to 1024, the count to zero.
// Stall: a finished result waits in the output register; a following command
// may still be accepted and computed, and stalls only at its own handoff.
// ----------------------------------------------------------------------------
module random_index_picker_no_repeat #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rip_cfg_if.sink   cfg_i,
  rip_in_if.sink    in_i,
  rip_out_if.source out_o
);
  import rip_pkg::*;

  rip_ctl_t ctl;
  rip_sts_t sts;

  assign cfg_i.ready = 1'b1;

  rip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rip_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_i.valid),
    .cfg_size_i     (cfg_i.size_in_use),
    .cmd_i          (in_i.cmd),
    .random_value_i (in_i.random_value),
    .index_i        (in_i.index),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .status_o       (out_o.status),
    .picked_index_o (out_o.picked_index),
    .count_after_o  (out_o.count_after)
  );
endmodule
`default_nettype wire

[tb/tb_random_index_picker_no_repeat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_index_picker_no_repeat
// Self-checking bench for the no-repeat index picker. A shadow permutation
// table and draw count predict every pick, claim, clear and unknown command.
// Results are checked in order against that prediction. Bursty command
// traffic, a stalling result sink and several range sizes are used,
// including zero and values above the table depth.
// ----------------------------------------------------------------------------
module tb_random_index_picker_no_repeat;
  import rip_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned RANDOM_ITEMS = 1730;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE       = DEPTH + 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [RV_W-1:0]  random_value;
    logic [IDX_W-1:0] index;
  } pick_cmd_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] picked_index;
    logic [CNT_W-1:0] count_after;
  } pick_res_t;

  logic clk_i;
  logic rst_ni;

  rip_cfg_if cfg_if ();
  rip_in_if  in_if ();
  rip_out_if out_if ();

  random_index_picker_no_repeat #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  logic [IDX_W-1:0]  shadow_perm [DEPTH];
  logic [CNT_W-1:0]  shadow_count;
  logic [SIZE_W-1:0] shadow_size;

  pick_cmd_t cmd_q[$];
  pick_res_t result_q[$];

  logic        in_fire    = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned ready_hold = 0;
  int unsigned ready_pct  = 100;

  int unsigned n_errors   = 0;
  int unsigned n_results  = 0;
  int unsigned n_pick_ok  = 0;
  int unsigned n_empty    = 0;
  int unsigned n_claim_ok = 0;
  int unsigned n_refused  = 0;
  int unsigned n_clear    = 0;
  int unsigned n_unknown  = 0;
  int unsigned n_cfg      = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < DEPTH; i++) shadow_perm[i] = IDX_W'(i);
    shadow_count = '0;
  endfunction

  function automatic pick_res_t predict_draw(pick_cmd_t c);
    int unsigned      span;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] tmp;
    pick_res_t        r;
    span = (shadow_size > DEPTH) ? DEPTH : shadow_size;
    cur = IDX_W'(shadow_count);
    r.status = ST_REFUSED;
    r.picked_index = '0;
    case (c.cmd)
      CMD_PICK: begin
        if (shadow_count < span) begin
          pos = IDX_W'(shadow_count + c.random_value % (span - shadow_count));
          tmp = shadow_perm[pos];
          shadow_perm[pos] = shadow_perm[cur];
          shadow_perm[cur] = tmp;
          r.picked_index = tmp;
          r.status = ST_DONE;
          shadow_count = shadow_count + 1'b1;
          n_pick_ok++;
        end else begin
          n_empty++;
        end
      end
      CMD_CLAIM: begin
        if (c.index < span && c.index >= shadow_count && shadow_perm[c.index] == c.index) begin
          tmp = shadow_perm[c.index];
          shadow_perm[c.index] = shadow_perm[cur];
          shadow_perm[cur] = tmp;
          r.picked_index = c.index;
          r.status = ST_DONE;
          shadow_count = shadow_count + 1'b1;
          n_claim_ok++;
        end else begin
          n_refused++;
        end
      end
      CMD_CLEAR: begin
        clear_shadow();
        r.status = ST_DONE;
        n_clear++;
      end
      default: begin
        n_unknown++;
      end
    endcase
    r.count_after = shadow_count;
    return r;
  endfunction

  // monitor: command accept, config write, result check
  always @(posedge clk_i) begin : monitor
    pick_cmd_t acc;
    pick_res_t want;
    pick_res_t got;
    in_fire <= in_if.valid && in_if.ready;
    if (cfg_if.valid && cfg_if.ready) begin
      shadow_size = cfg_if.size_in_use;
      n_cfg++;
    end
    if (in_if.valid && in_if.ready) begin
      acc.cmd = in_if.cmd;
      acc.random_value = in_if.random_value;
      acc.index = in_if.index;
      result_q = {result_q, predict_draw(acc)};
    end
    if (out_if.valid && out_if.ready) begin
      got.status = out_if.status;
      got.picked_index = out_if.picked_index;
      got.count_after = out_if.count_after;
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: unexpected transaction status %0b index %0d count %0d",
                   got.status, got.picked_index, got.count_after);
      end else begin
        want = result_q.pop_front();
        if (want.status != got.status || want.picked_index != got.picked_index ||
            want.count_after != got.count_after) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR: result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                     n_results, want.status, want.picked_index, want.count_after,
                     got.status, got.picked_index, got.count_after);
        end
      end
    end
  end

  // command driver: bursts with random gaps
  always @(negedge clk_i) begin : driver
    logic      nxt_valid;
    pick_cmd_t nxt_cmd;
    if (!in_if.valid || in_fire) begin
      nxt_valid = 1'b0;
      nxt_cmd = '0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 24);
      end
      if (burst_left != 0 && cmd_q.size() != 0) begin
        nxt_cmd = cmd_q.pop_front();
        nxt_valid = 1'b1;
        burst_left--;
      end else if (burst_left == 0 && gap_left != 0) begin
        gap_left--;
      end
      in_if.valid <= nxt_valid;
      if (nxt_valid) begin
        in_if.cmd <= nxt_cmd.cmd;
        in_if.random_value <= nxt_cmd.random_value;
        in_if.index <= nxt_cmd.index;
      end
    end
  end

  // result sink: stall density changes after each randomly drawn hold period
  always @(negedge clk_i) begin : receiver
    if (ready_hold == 0) begin
      ready_hold = $urandom_range(64, 512);
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 75;
        2:       ready_pct = 35;
        default: ready_pct = 8;
      endcase
    end
    ready_hold--;
    out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
  end

  task automatic push(input logic [CMD_W-1:0] cmd, input logic [RV_W-1:0] rv,
                      input logic [IDX_W-1:0] idx);
    pick_cmd_t c;
    c.cmd = cmd;
    c.random_value = rv;
    c.index = idx;
    cmd_q = {cmd_q, c};
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (cmd_q.size() != 0 || in_if.valid || result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] sz);
    drain();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.size_in_use <= sz;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : timeout
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned left;
    int unsigned n;
    int unsigned eff;
    int unsigned sz;
    int unsigned k;
    int unsigned phase;
    pick_cmd_t   c;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_PICK;
    in_if.random_value = '0;
    in_if.index = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.size_in_use = SIZE_RESET;
    shadow_size = SIZE_RESET;
    clear_shadow();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full range from reset
    push(CMD_PICK, '0, '0);
    push(CMD_PICK, '1, '0);
    push(CMD_PICK, 32'd10, '0);
    push(CMD_CLAIM, '0, 10'd12);
    push(CMD_CLAIM, '0, 10'd0);
    push(CMD_CLAIM, '0, 10'd1023);
    push(CMD_CLAIM, '1, 10'd1023);
    push(CMD_CLAIM, '0, 10'd512);
    push(CMD_UNKNOWN, '1, '1);
    push(CMD_CLEAR, '1, '1);
    push(CMD_CLAIM, '0, 10'd1023);
    // single-entry range: exhaustion and out-of-range claim
    write_size(SIZE_W'(1));
    push(CMD_PICK, '1, '0);
    push(CMD_PICK, '0, '0);
    push(CMD_CLAIM, '0, 10'd0);
    push(CMD_CLAIM, '0, 10'd1);
    push(CMD_CLEAR, '0, '0);
    // empty range
    write_size(SIZE_W'(0));
    push(CMD_PICK, '0, '0);
    push(CMD_CLAIM, '0, 10'd0);
    // oversized register value clips to the table depth
    write_size('1);
    push(CMD_PICK, '1, '0);
    push(CMD_CLAIM, '0, 10'd1023);
    push(CMD_PICK, '0, '1);
    // range lowered to the draw count
    write_size(SIZE_W'(2));
    push(CMD_PICK, '0, '0);
    push(CMD_CLEAR, '0, '0);

    left = RANDOM_ITEMS;
    phase = 0;
    while (left > 0) begin
      k = $urandom_range(0, 99);
      if (k < 65) sz = $urandom_range(1, 40);
      else if (k < 80) sz = $urandom_range(41, DEPTH - 1);
      else if (k < 88) sz = DEPTH;
      else if (k < 95) sz = $urandom_range(DEPTH + 1, 2047);
      else sz = 0;
      write_size(SIZE_W'(sz));
      eff = (sz > DEPTH) ? DEPTH : sz;
      n = (sz == 0) ? $urandom_range(4, 12) : $urandom_range(20, 90);
      if (n > left) n = left;
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && phase % 5 == 0) drain();
        c.random_value = $urandom();
        c.index = IDX_W'($urandom_range(0, DEPTH - 1));
        k = $urandom_range(0, 99);
        if (k < 56) begin
          c.cmd = CMD_PICK;
        end else if (k < 91) begin
          c.cmd = CMD_CLAIM;
          if (eff != 0 && $urandom_range(0, 3) != 0) c.index = IDX_W'($urandom_range(0, eff - 1));
        end else if (k < 96) begin
          c.cmd = CMD_CLEAR;
        end else begin
          c.cmd = CMD_UNKNOWN;
        end
        cmd_q = {cmd_q, c};
      end
      left -= n;
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    n_errors += result_q.size();
    $display("Run covered %0d size writes over %0d random phases, %0d results checked.",
             n_cfg, phase, n_results);
    $display("Picks %0d ok / %0d exhausted, claims %0d ok / %0d refused, %0d clears, %0d unknown.",
             n_pick_ok, n_empty, n_claim_ok, n_refused, n_clear, n_unknown);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
